/* rtl/bmm_pkg.sv */
package bmm_pkg;

   localparam int BARCODE_W  = 64;
   localparam int INDEX_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 2;
   localparam int BASES_W    = 6;
   localparam int DIST_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [BASES_W-1:0] MAX_BASES = 6'd32;
   localparam logic [INDEX_W-1:0] NO_INDEX  = 16'hFFFF;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_MISMATCH_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_COUNT     = 1'd1;

   localparam logic [LIMIT_W-1:0] RESET_LIMIT = 2'd1;
   localparam logic [BASES_W-1:0] RESET_BASES = 6'd10;

   localparam logic [STATUS_W-1:0] LS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] LS_CONFLICT = 2'd1;
   localparam logic [STATUS_W-1:0] LS_FULL     = 2'd2;

   // item broadcast to every cell while it walks the row
   typedef struct packed {
      logic                 cmd;
      logic                 ovw;
      logic [DIST_W-1:0]    maxd;
      logic [BARCODE_W-1:0] code;
      logic [BARCODE_W-1:0] mask;
      logic [INDEX_W-1:0]   pidx;
   } bcast_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic               hit;
      logic               stored;
      logic [INDEX_W-1:0] idx;
   } token_type;

endpackage

/* rtl/bmm_cell.sv */
module bmm_cell import bmm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  bcast_type bc,
   input  token_type tok_prev,
   output token_type tok_out
);

   logic [BARCODE_W-1:0] bar_ff;
   logic [INDEX_W-1:0]   idx_ff;
   logic                 vld_ff;
   token_type            tok_ff;
   token_type            tok_in;
   logic                 open;
   logic                 match;
   logic                 wr_idx;
   logic                 wr_new;

   // 1 when fewer than maxd+1 bases differ
   function automatic logic near_enough(input logic [BARCODE_W-1:0] x,
                                        input logic [DIST_W-1:0] maxd);
      logic [2:0] grp [0:7];
      logic [5:0] sum;
      begin
         for (int g = 0; g < 8; g++) begin
            grp[g] = 3'd0;
            for (int k = 0; k < 4; k++) begin
               grp[g] = grp[g] + {2'd0, x[8*g+2*k] | x[8*g+2*k+1]};
            end
         end
         sum = 6'd0;
         for (int g = 0; g < 8; g++) begin
            sum = sum + {3'd0, grp[g]};
         end
         near_enough = (sum <= {3'd0, maxd});
      end
   endfunction

   always_comb begin
      match  = vld_ff && near_enough((bc.code ^ bar_ff) & bc.mask, bc.maxd);
      open   = tok_prev.active && !tok_prev.hit && !tok_prev.stored;
      tok_in = tok_prev;
      wr_idx = 1'b0;
      wr_new = 1'b0;
      if (open) begin
         if (match) begin
            tok_in.hit = 1'b1;
            tok_in.idx = idx_ff;
            wr_idx     = (bc.cmd == CMD_LOAD) && bc.ovw;
         end else if (!vld_ff && bc.cmd == CMD_LOAD) begin
            // first free slot: entries fill from the head of the row
            tok_in.stored = 1'b1;
            wr_new        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         if (wr_new) begin
            vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_new) begin
         bar_ff <= bc.code;
      end
      if (wr_new || wr_idx) begin
         idx_ff <= bc.pidx;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* rtl/barcode_mismatch_matcher_unit.sv */
// a request is registered, its search token walks the entry cells one cell a cycle, and the response
//   is registered as the token leaves the row; one word at a time: no new request is accepted
//   until the last response has been taken
// reset: all entries invalid, mismatch_limit = 1, base_count = 10;
//   stored barcodes and indices are undefined until loaded
module barcode_mismatch_matcher_unit import bmm_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [BARCODE_W-1:0]  req_barcode,
   input  logic [INDEX_W-1:0]    req_protein_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [INDEX_W-1:0]    rsp_match_index,
   output logic [STATUS_W-1:0]   rsp_load_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_RESP} state_type;

   state_type            state_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [BASES_W-1:0]   bases_ff;
   bcast_type            bc_ff;
   logic                 launch_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [INDEX_W-1:0]   rsp_idx_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic [BASES_W-1:0]   bases_eff;
   logic [LIMIT_W-1:0]   limit_eff;
   logic [BARCODE_W-1:0] mask;
   logic [DIST_W-1:0]    maxd;
   token_type            tok [0:TABLE_ENTRIES];
   token_type            tok_end;
   logic [TABLE_ENTRIES:0] tok_act;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RESET_LIMIT;
         bases_ff <= RESET_BASES;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MISMATCH_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            REG_BASE_COUNT:     bases_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      bases_eff = (bases_ff > MAX_BASES) ? MAX_BASES : bases_ff;
      limit_eff = (limit_ff > 2'd2) ? 2'd2 : limit_ff;
      // a shift of 64 gives zero, so the full-width case falls out as all ones
      mask      = (64'd1 << {bases_eff, 1'b0}) - 64'd1;
      if (req_cmd == CMD_QUERY) begin
         maxd = {1'b0, limit_eff};
      end else begin
         // loads check against twice the limit
         maxd = {limit_eff, 1'b0};
      end
   end

   assign tok[0]  = '{active: launch_ff, hit: 1'b0, stored: 1'b0, idx: NO_INDEX};
   assign tok_end = tok[TABLE_ENTRIES];

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      bmm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bc       (bc_ff),
         .tok_prev (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_act
      assign tok_act[i] = tok[i].active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff   <= ST_BUSY;
                  launch_ff  <= 1'b1;
                  bc_ff.cmd  <= req_cmd;
                  bc_ff.ovw  <= (limit_eff == 2'd0);
                  bc_ff.maxd <= maxd;
                  bc_ff.code <= req_barcode & mask;
                  bc_ff.mask <= mask;
                  bc_ff.pidx <= req_protein_index;
               end
            end
            ST_BUSY: begin
               if (tok_end.active) begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
                  if (bc_ff.cmd == CMD_QUERY) begin
                     rsp_found_ff  <= tok_end.hit;
                     rsp_idx_ff    <= tok_end.hit ? tok_end.idx : NO_INDEX;
                     rsp_status_ff <= LS_OK;
                  end else begin
                     rsp_found_ff <= 1'b0;
                     rsp_idx_ff   <= NO_INDEX;
                     priority if (tok_end.hit) begin
                        rsp_status_ff <= bc_ff.ovw ? LS_OK : LS_CONFLICT;
                     end else if (tok_end.stored) begin
                        rsp_status_ff <= LS_OK;
                     end else begin
                        rsp_status_ff <= LS_FULL;
                     end
                  end
               end
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_load_status = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_act))
      else $error("more than one search token in the cell row");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> state_ff == ST_BUSY)
      else $error("token left the row outside a search");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while a response is pending");

   a_load_not_found: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && bc_ff.cmd == CMD_LOAD |-> !rsp_found && rsp_match_index == NO_INDEX)
      else $error("load word reported a match");
`endif

endmodule
